// ===== hdl/autocorrelation_frequency_estimator_macros.svh =====
// Assertion macros for the autocorrelation frequency estimator checker
`ifndef AUTOCORRELATION_FREQUENCY_ESTIMATOR_MACROS_SVH
`define AUTOCORRELATION_FREQUENCY_ESTIMATOR_MACROS_SVH

// clocked assertion, off while in reset
`define AFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same, for a non-overlapping implication
`define AFE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/afe_pkg.sv =====
// Shared constants and types of the autocorrelation frequency estimator
package afe_pkg;
  localparam int MAX_SAMPLES_DEF = 512;
  localparam int MAX_LAGS_DEF    = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int RATE_W   = 24;
  localparam int LAGCFG_W = 10;
  localparam int CFG_W    = 24;
  localparam int LAGOUT_W = 9;
  localparam int FREQ_W   = 31;
  localparam int DIVD_W   = 32;

  localparam logic [RATE_W-1:0]   RATE_RST     = 24'd100000;
  localparam logic [LAGCFG_W-1:0] LAG_COUNT_RST = 10'd300;

  typedef enum logic [0:0] {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_LAG_COUNT   = 1'b1
  } cfg_idx_t;
endpackage

// ===== hdl/afe_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module afe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/autocorrelation_frequency_estimator.sv =====
// Autocorrelation frequency estimator: one beat per sample, then lag sums, peak search and
// frequency divide on a closed record. For a record of N samples with L lags, each lag s
// below L sums N-s products through the single 16x16 multiplier fed by
// two copies of the sample store; two peak scans then run over the lag-sum memory,
// and a bit-serial divide by the lag distance gives the frequency.
// No sample is taken while a record is being processed; a finished result waits in the
// output register while the next record loads.
module autocorrelation_frequency_estimator
  import afe_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int MAX_LAGS    = MAX_LAGS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [LAGOUT_W-1:0]    first_lag,
  output logic [LAGOUT_W-1:0]    second_lag,
  output logic [LAGOUT_W-1:0]    lag_distance,
  output logic [FREQ_W-1:0]      frequency_q8,
  output logic                   valid_res,
  output logic                   overflow
);
  localparam int SA_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int LA_W   = $clog2(MAX_LAGS);
  localparam int LAG_W  = $clog2(MAX_LAGS + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + $clog2(MAX_SAMPLES);
  localparam int CMP_W  = SUM_W + CNT_W;
  localparam int DCNT_W = $clog2(DIVD_W);

  typedef enum logic [2:0] {
    S_LOAD, S_ACC_ISSUE, S_ACC_DRAIN, S_SCAN_RD, S_SCAN_MUL, S_SCAN_CMP, S_DIV, S_DONE
  } state_t;

  state_t state;

  logic [RATE_W-1:0]   rate;
  logic [LAGCFG_W-1:0] lag_count;

  logic [CNT_W-1:0] cnt, n_len, i;
  logic             ovf, ovf_rec;
  logic [LAG_W-1:0] lags, s, k, best_k, lag1, lag2;
  logic             pass, have;

  logic                     rd_v, rd_last, pr_v, pr_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  logic [SUM_W-2:0] best_v;
  logic [CMP_W-1:0] prod_a, prod_b;
  logic             cur_pos;

  logic [DIVD_W-1:0]  quo;
  logic [LAG_W-1:0]   rem, lag_dist;
  logic [DCNT_W-1:0]  dcnt;

  // memory ports
  logic                   smp_we;
  logic [SA_W-1:0]        smp_waddr, raddr_a, raddr_b;
  logic [SAMPLE_BITS-1:0] rd_a, rd_b;
  logic                   lag_we;
  logic [SUM_W-1:0]       lag_wdata, lag_rd;

  // combinational helpers
  logic [CNT_W-1:0] cnt_next, n_now;
  logic             ovf_next;
  logic [31:0]      lags_cfg, lags_now;
  logic [LAG_W:0]   trial;
  logic             q_bit;
  logic [LAG_W-1:0] k_inc;
  logic             cmp_win;

  always_comb begin
    smp_we    = (state == S_LOAD) && sample_valid && (32'(cnt) < MAX_SAMPLES);
    smp_waddr = cnt[SA_W-1:0];
    raddr_a   = i[SA_W-1:0];
    raddr_b   = i[SA_W-1:0] + SA_W'(s);
    lag_we    = pr_v && pr_last;
    lag_wdata = acc + SUM_W'(prod);
    cnt_next  = smp_we ? cnt + CNT_W'(1) : cnt;
    ovf_next  = ovf || ((state == S_LOAD) && sample_valid && !smp_we);
    n_now     = cnt_next;
    lags_cfg  = (32'(lag_count) > MAX_LAGS) ? 32'(MAX_LAGS) : 32'(lag_count);
    lags_now  = (lags_cfg > 32'(n_now)) ? 32'(n_now) : lags_cfg;
    trial     = {rem, quo[DIVD_W-1]};
    q_bit     = trial >= {1'b0, lag_dist};
    k_inc     = k + LAG_W'(1);
    cmp_win   = cur_pos && (!have || (prod_a > prod_b));
  end

  assign sample_ready = (state == S_LOAD);

  afe_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_smp_a (
    .clk, .we(smp_we), .waddr(smp_waddr), .wdata(sample), .raddr(raddr_a), .rdata(rd_a)
  );
  afe_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_smp_b (
    .clk, .we(smp_we), .waddr(smp_waddr), .wdata(sample), .raddr(raddr_b), .rdata(rd_b)
  );
  afe_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LAGS)) u_lag (
    .clk, .we(lag_we), .waddr(s[LA_W-1:0]), .wdata(lag_wdata),
    .raddr(k[LA_W-1:0]), .rdata(lag_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      rate         <= RATE_RST;
      lag_count    <= LAG_COUNT_RST;
      cnt          <= '0;
      ovf          <= 1'b0;
      rd_v         <= 1'b0;
      pr_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SAMPLE_RATE: rate      <= cfg_data[RATE_W-1:0];
          CFG_LAG_COUNT:   lag_count <= cfg_data[LAGCFG_W-1:0];
        endcase
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      // multiply-accumulate pipeline
      rd_v    <= 1'b0;
      pr_v    <= rd_v;
      pr_last <= rd_last;
      prod    <= $signed(rd_a) * $signed(rd_b);
      if (pr_v) begin
        acc <= pr_last ? '0 : lag_wdata;
      end

      unique case (state)
        S_LOAD: begin
          if (sample_valid) begin
            cnt <= cnt_next;
            ovf <= ovf_next;
            if (last) begin
              cnt      <= '0;
              ovf      <= 1'b0;
              ovf_rec  <= ovf_next;
              n_len    <= n_now;
              lags     <= LAG_W'(lags_now);
              s        <= '0;
              i        <= '0;
              acc      <= '0;
              k        <= '0;
              best_k   <= '0;
              have     <= 1'b0;
              pass     <= 1'b0;
              lag1     <= '0;
              lag2     <= '0;
              lag_dist <= '0;
              quo      <= '0;
              if (lags_now == 0) begin
                state <= S_DONE;
              end else begin
                state <= S_ACC_ISSUE;
              end
            end
          end
        end
        S_ACC_ISSUE: begin
          rd_v    <= 1'b1;
          rd_last <= (32'(i) + 32'(s) + 1 == 32'(n_len));
          i       <= i + CNT_W'(1);
          if (32'(i) + 32'(s) + 1 == 32'(n_len)) begin
            state <= S_ACC_DRAIN;
          end
        end
        S_ACC_DRAIN: begin
          if (pr_v && pr_last) begin
            i <= '0;
            s <= s + LAG_W'(1);
            if (s + LAG_W'(1) == lags) begin
              state <= S_SCAN_RD;
            end else begin
              state <= S_ACC_ISSUE;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_MUL;
        end
        S_SCAN_MUL: begin
          cur_pos <= !lag_rd[SUM_W-1] && (|lag_rd);
          prod_a  <= CMP_W'(lag_rd[SUM_W-2:0]) * CMP_W'(n_len - CNT_W'(best_k));
          prod_b  <= CMP_W'(best_v) * CMP_W'(n_len - CNT_W'(k));
          state   <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (cmp_win) begin
            best_k <= k;
            best_v <= lag_rd[SUM_W-2:0];
            have   <= 1'b1;
          end
          k     <= k_inc;
          state <= S_SCAN_RD;
          if (k_inc >= lags) begin
            if (!pass) begin
              lag1   <= cmp_win ? k : best_k;
              pass   <= 1'b1;
              have   <= 1'b0;
              best_k <= '0;
              k      <= (cmp_win ? k : best_k) + LAG_W'(2);
              if (32'(cmp_win ? k : best_k) + 2 >= 32'(lags)) begin
                state <= S_DONE;
              end
            end else begin
              lag2 <= cmp_win ? k : best_k;
              if ((cmp_win ? k : best_k) > lag1) begin
                lag_dist <= (cmp_win ? k : best_k) - lag1;
                quo      <= {rate, 8'd0};
                rem      <= '0;
                dcnt     <= '0;
                state    <= S_DIV;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DIV: begin
          rem  <= q_bit ? LAG_W'(trial - {1'b0, lag_dist}) : LAG_W'(trial);
          quo  <= {quo[DIVD_W-2:0], q_bit};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(DIVD_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            first_lag    <= LAGOUT_W'(lag1);
            second_lag   <= LAGOUT_W'(lag2);
            valid_res    <= lag2 > lag1;
            lag_distance <= (lag2 > lag1) ? LAGOUT_W'(lag_dist) : '0;
            frequency_q8 <= (lag2 > lag1) ? quo[FREQ_W-1:0] : '0;
            overflow     <= ovf_rec;
            state        <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== hdl/afe_checker.sv =====
// Port-level checks for the autocorrelation frequency estimator
`include "autocorrelation_frequency_estimator_macros.svh"
module afe_checker
  import afe_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [LAGOUT_W-1:0] first_lag,
  input logic [LAGOUT_W-1:0] second_lag,
  input logic [LAGOUT_W-1:0] lag_distance,
  input logic [FREQ_W-1:0]   frequency_q8,
  input logic                valid_res
);
  `AFE_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid, "result beat dropped before taken")
  `AFE_ASSERT(a_valid_order, !result_valid || (valid_res == (second_lag > first_lag)), "valid_res disagrees with lag order")
  `AFE_ASSERT(a_invalid_zero, !result_valid || valid_res || (lag_distance == '0 && frequency_q8 == '0), "invalid result carries non-zero distance or frequency")
  `AFE_ASSERT(a_dist, !result_valid || !valid_res || (lag_distance == LAGOUT_W'(second_lag - first_lag)), "lag distance mismatch")
endmodule

bind autocorrelation_frequency_estimator afe_checker u_afe_checker (
  .clk, .rst, .result_valid, .result_ready, .first_lag, .second_lag,
  .lag_distance, .frequency_q8, .valid_res
);

// ===== bench/afe_checker.sv =====
// Scoreboard for the autocorrelation frequency estimator: predicts each record's estimate
`timescale 1ns / 1ps
module afe_scoreboard
  import afe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                sample_valid,
  input  logic                sample_ready,
  input  logic [15:0]         sample,
  input  logic                last,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic [LAGOUT_W-1:0] first_lag,
  input  logic [LAGOUT_W-1:0] second_lag,
  input  logic [LAGOUT_W-1:0] lag_distance,
  input  logic [FREQ_W-1:0]   frequency_q8,
  input  logic                valid_res,
  input  logic                overflow,
  output int                  errors,
  output int                  pending
);
  localparam int DEPTH = MAX_SAMPLES_DEF;

  typedef struct packed {
    logic [LAGOUT_W-1:0] first;
    logic [LAGOUT_W-1:0] second;
    logic [LAGOUT_W-1:0] span;
    logic [FREQ_W-1:0]   freq;
    logic                valid;
    logic                ovf;
  } estimate_t;

  estimate_t          estimate_q[$];
  logic signed [15:0] record_buf[DEPTH];
  longint             lag_acc[DEPTH];
  int                 record_len;
  bit                 dropped;
  logic [RATE_W-1:0]  rate_hz;
  logic [LAGCFG_W-1:0] lag_cfg;

  // a/na > b/nb, exact
  function automatic bit ratio_gt(longint a, int na, longint b, int nb);
    longint unsigned ua, ub, qa, qb, ra, rb;
    ua = a; ub = b;
    qa = ua / na; qb = ub / nb;
    ra = ua % na; rb = ub % nb;
    if (qa != qb) return qa > qb;
    return ra * nb > rb * na;
  endfunction

  function automatic int best_lag_from(int from, int lags, int n);
    int best;
    bit have;
    best = 0; have = 0;
    for (int k = from; k < lags; k++) begin
      if (lag_acc[k] > 0 &&
          (!have || ratio_gt(lag_acc[k], n - k, lag_acc[best], n - best))) begin
        best = k;
        have = 1;
      end
    end
    return best;
  endfunction

  function automatic estimate_t estimate_record();
    estimate_t e;
    int lags, l1, l2;
    longint unsigned f;
    lags = (lag_cfg > DEPTH) ? DEPTH : lag_cfg;
    if (lags > record_len) lags = record_len;
    for (int s = 0; s < lags; s++) begin
      lag_acc[s] = 0;
      for (int i = 0; i + s < record_len; i++)
        lag_acc[s] += longint'(record_buf[i]) * longint'(record_buf[i + s]);
    end
    l1 = best_lag_from(0, lags, record_len);
    l2 = best_lag_from(l1 + 2, lags, record_len);
    e = '0;
    e.first = LAGOUT_W'(l1);
    e.second = LAGOUT_W'(l2);
    e.ovf = dropped;
    if (l2 > l1) begin
      e.valid = 1'b1;
      e.span = LAGOUT_W'(l2 - l1);
      f = (longint'(rate_hz) << 8) / (l2 - l1);
      e.freq = f[FREQ_W-1:0];
    end
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    estimate_t w;
    if (rst) begin
      estimate_q.delete();
      record_len = 0;
      dropped = 0;
      rate_hz = RATE_RST;
      lag_cfg = LAG_COUNT_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SAMPLE_RATE) rate_hz = cfg_data[RATE_W-1:0];
        else lag_cfg = cfg_data[LAGCFG_W-1:0];
      end
      if (result_valid && result_ready) begin
        if (estimate_q.size() == 0) begin
          report("unexpected estimate, first_lag", first_lag, 0);
        end else begin
          w = estimate_q.pop_front();
          if (first_lag !== w.first) report("first_lag", first_lag, w.first);
          if (second_lag !== w.second) report("second_lag", second_lag, w.second);
          if (lag_distance !== w.span) report("lag_distance", lag_distance, w.span);
          if (frequency_q8 !== w.freq) report("frequency_q8", frequency_q8, w.freq);
          if (valid_res !== w.valid) report("valid_res", valid_res, w.valid);
          if (overflow !== w.ovf) report("overflow", overflow, w.ovf);
        end
      end
      if (sample_valid && sample_ready) begin
        if (record_len < DEPTH) begin
          record_buf[record_len] = sample;
          record_len++;
        end else begin
          dropped = 1;
        end
        if (last) begin
          estimate_q.push_back(estimate_record());
          record_len = 0;
          dropped = 0;
        end
      end
    end
    pending = estimate_q.size();
  end
endmodule

// ===== bench/tb_autocorrelation_frequency_estimator.sv =====
// Top of the estimator bench: clock, reset, record stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_autocorrelation_frequency_estimator;
  import afe_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic                clk = 0;
  logic                rst = 1;
  logic                cfg_we = 0;
  logic                cfg_index = CFG_SAMPLE_RATE;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                sample_valid = 0;
  logic                sample_ready;
  logic [15:0]         sample = '0;
  logic                last = 0;
  logic                result_valid;
  logic                result_ready = 0;
  logic [LAGOUT_W-1:0] first_lag, second_lag, lag_distance;
  logic [FREQ_W-1:0]   frequency_q8;
  logic                valid_res, overflow;
  int                  errors, pending;
  int                  items = 0;
  longint              cycles = 0;
  bit                  calm = 0;
  bit                  hold_tog = 0;
  bit                  hold_seen = 0;
  int                  hold_cnt = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  autocorrelation_frequency_estimator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample), .last(last),
    .result_valid(result_valid), .result_ready(result_ready), .first_lag(first_lag),
    .second_lag(second_lag), .lag_distance(lag_distance), .frequency_q8(frequency_q8),
    .valid_res(valid_res), .overflow(overflow)
  );

  afe_scoreboard u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample), .last(last),
    .result_valid(result_valid), .result_ready(result_ready), .first_lag(first_lag),
    .second_lag(second_lag), .lag_distance(lag_distance), .frequency_q8(frequency_q8),
    .valid_res(valid_res), .overflow(overflow), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 0;
    end else if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_cnt = 3000;
      result_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      result_ready <= 0;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_beat(logic [15:0] s, logic l);
    while (!calm && $urandom_range(99) < 32) begin
      sample_valid <= 0;
      @(posedge clk);
    end
    sample_valid <= 1;
    sample <= s;
    last <= l;
    @(posedge clk iff sample_ready);
    items++;
  endtask

  // kind 0: periodic with noise, 1: full-range random, 2: constant
  task automatic send_record(int n, int kind);
    logic [15:0] wave[16];
    logic [15:0] v;
    int p;
    p = $urandom_range(2, 12);
    for (int k = 0; k < 16; k++) wave[k] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = wave[i % p] ^ 16'($urandom_range(15));
        1: v = 16'($urandom);
        default: v = wave[0];
      endcase
      send_beat(v, i == n - 1);
    end
  endtask

  task automatic quiesce();
    sample_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_cfg(logic [RATE_W-1:0] rate, logic [LAGCFG_W-1:0] lags);
    cfg_we <= 1;
    cfg_index <= CFG_SAMPLE_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_index <= CFG_LAG_COUNT;
    cfg_data <= CFG_W'(lags);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic run_random(int target);
    int r, n;
    while (items < target) begin
      r = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
      send_record(n, (r < 70) ? 0 : (r < 90) ? 1 : 2);
    end
    quiesce();
  endtask

  initial begin
    int base;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, single sample, silence, noisy periodic, then zero and all-ones config
    for (int i = 0; i < 6; i++) send_beat(i[0] ? 16'h8000 : 16'h7fff, i == 5);
    send_beat(16'h8000, 1);
    for (int i = 0; i < 4; i++) send_beat(16'h0000, i == 3);
    send_record(12, 0);
    quiesce();
    set_cfg('0, '0);
    send_record(8, 0);
    quiesce();
    set_cfg('1, '1);
    send_record(20, 0);
    quiesce();
    // store full, last three beats dropped
    set_cfg(RATE_RST, 10'd512);
    send_record(515, 0);
    quiesce();

    base = items;
    set_cfg(RATE_RST, LAG_COUNT_RST);
    run_random(base + 250);
    set_cfg('1, 10'd3);
    hold_tog = ~hold_tog;
    run_random(base + 450);
    calm = 1;
    set_cfg(24'd1, 10'd512);
    run_random(base + 700);
    calm = 0;
    set_cfg(RATE_W'($urandom_range(1, 16777215)), LAGCFG_W'($urandom_range(3, 64)));
    run_random(base + 950);
    set_cfg(RATE_W'($urandom_range(1, 16777215)), LAGCFG_W'($urandom_range(3, 512)));
    run_random(base + 1180);

    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
